// File: rtl/tccs_pkg.sv
// ---------------------------------------------------------------------------
// Text console cursor/scroll engine: shared definitions
// Item types, action and character codes and default geometry.
// ---------------------------------------------------------------------------
package tccs_pkg;

   // default screen geometry
   localparam int COLUMNS_DEF  = 80;
   localparam int ROWS_DEF     = 25;
   localparam int TAB_STOP_DEF = 4;

   // action codes
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // character codes
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;

   // attribute after reset
   localparam logic [7:0] ATTR_RESET = 8'd7;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] char_code;
      logic [6:0] read_col;
      logic [4:0] read_row;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_offset;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } rsp_type;

   // finished result from the sequencer
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } done_type;

   // byte write enables of the screen memory
   typedef struct packed {
      logic char_we;
      logic attr_we;
   } mem_we_type;

endpackage

// File: rtl/tccs_screen_mem.sv
// ---------------------------------------------------------------------------
// Screen cell memory
// Character and attribute planes, one write and one registered read a cycle.
// ---------------------------------------------------------------------------
module tccs_screen_mem #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic                clock,
   input  tccs_pkg::mem_we_type wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [7:0]          wr_char,
   input  logic [7:0]          wr_attr,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [7:0]          rd_char,
   output logic [7:0]          rd_attr
);
   import tccs_pkg::*;

   logic [7:0] char_mem [DEPTH];
   logic [7:0] attr_mem [DEPTH];
   logic [7:0] rd_char_ff;
   logic [7:0] rd_attr_ff;

   // write port, byte planes enabled separately
   always_ff @(posedge clock) begin
      if (wr_en.char_we) begin
         char_mem[wr_addr] <= wr_char;
      end
      if (wr_en.attr_we) begin
         attr_mem[wr_addr] <= wr_attr;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_char_ff <= char_mem[rd_addr];
         rd_attr_ff <= attr_mem[rd_addr];
      end
   end

   assign rd_char = rd_char_ff;
   assign rd_attr = rd_attr_ff;

endmodule

// File: rtl/tccs_seq.sv
// ---------------------------------------------------------------------------
// Cursor sequencer
// Walks one item through cursor update, memory sweeps and cell reads.
// The screen is a ring of rows: scrolling moves the top-row base and blanks
// one row instead of moving the whole screen.
// ---------------------------------------------------------------------------
module tccs_seq #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4,
   parameter int AW       = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  tccs_pkg::req_type    req,
   output logic                 idle,
   input  logic [7:0]           default_attr,
   input  logic                 out_free,
   output tccs_pkg::done_type   done,
   output tccs_pkg::mem_we_type mem_we,
   output logic [AW-1:0]        mem_wr_addr,
   output logic [7:0]           mem_wr_char,
   output logic [7:0]           mem_wr_attr,
   output logic                 mem_rd_en,
   output logic [AW-1:0]        mem_rd_addr,
   input  logic [7:0]           mem_rd_char,
   input  logic [7:0]           mem_rd_attr
);
   import tccs_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int XW    = $clog2(COLUMNS);
   localparam int YW    = $clog2(ROWS);
   localparam int LW    = AW;
   localparam int TW    = $clog2(TAB_STOP);
   localparam int NW    = $clog2(TAB_STOP + 1);
   localparam int XW1   = XW + 1;
   localparam int YW1   = YW + 1;
   localparam int LW1   = LW + 1;
   localparam int TW1   = TW + 1;

   typedef enum logic [7:0] {
      S_INIT   = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_PUT    = 8'b0000_0100,
      S_SCROLL = 8'b0000_1000,
      S_CLEAR  = 8'b0001_0000,
      S_RDADDR = 8'b0010_0000,
      S_RDDATA = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [XW-1:0]   x_ff, x_in;
   logic [YW-1:0]   y_ff, y_in;
   logic [LW-1:0]   lin_ff, lin_in;       // y * COLUMNS + x
   logic [LW-1:0]   base_ff, base_in;     // physical cell of logical row 0
   logic [TW-1:0]   tpos_ff, tpos_in;     // x mod TAB_STOP
   logic [NW-1:0]   cnt_ff, cnt_in;       // characters still to put
   logic [LW-1:0]   sw_ff, sw_in;
   logic [LW-1:0]   sw_base_ff, sw_base_in;
   logic [LW-1:0]   sw_last_ff, sw_last_in;
   logic [7:0]      ch_ff, ch_in;
   logic [LW-1:0]   rd_lin_ff, rd_lin_in;
   logic            rd_ok_ff, rd_ok_in;
   logic [7:0]      cell_char_ff, cell_char_in;
   logic [7:0]      cell_attr_ff, cell_attr_in;

   logic [LW-1:0]   phys_src;
   logic [LW:0]     phys_sum;
   logic [LW-1:0]   phys_addr;
   logic [LW:0]     base_sum;
   logic [LW-1:0]   base_next;
   logic [LW-1:0]   sweep_addr;

   logic [XW:0]     put_x;
   logic [YW:0]     put_y;
   logic [LW:0]     put_lin;
   logic [TW-1:0]   put_tpos;
   logic [TW:0]     tpos_inc;
   logic            put_wr;
   logic            put_scroll;

   // shared address unit: logical cell to physical cell through the row ring
   assign phys_src  = (state_ff == S_RDADDR) ? rd_lin_ff : lin_ff;
   assign phys_sum  = {1'b0, phys_src} + {1'b0, base_ff};
   assign phys_addr = (phys_sum >= LW1'(CELLS)) ? LW'(phys_sum - LW1'(CELLS))
                                                : phys_sum[LW-1:0];

   // top-row base after one scroll
   assign base_sum  = {1'b0, base_ff} + LW1'(COLUMNS);
   assign base_next = (base_sum >= LW1'(CELLS)) ? LW'(base_sum - LW1'(CELLS))
                                                : base_sum[LW-1:0];

   assign sweep_addr = sw_base_ff + sw_ff;

   // one character step: move, wrap, detect scroll
   always_comb begin
      put_wr   = 1'b0;
      put_x    = '0;
      put_y    = {1'b0, y_ff};
      put_lin  = {1'b0, lin_ff};
      put_tpos = '0;
      tpos_inc = {1'b0, tpos_ff} + 1'b1;
      if (ch_ff == CH_NEWLINE) begin
         put_y   = {1'b0, y_ff} + 1'b1;
         put_lin = {1'b0, lin_ff} - LW1'(x_ff) + LW1'(COLUMNS);
      end else if (ch_ff == CH_RETURN) begin
         put_lin = {1'b0, lin_ff} - LW1'(x_ff);
      end else begin
         put_wr   = 1'b1;
         put_x    = {1'b0, x_ff} + 1'b1;
         put_lin  = {1'b0, lin_ff} + 1'b1;
         put_tpos = (tpos_inc == TW1'(TAB_STOP)) ? '0 : tpos_inc[TW-1:0];
      end
      // full row wraps; offset already points at the next row
      if (put_x >= XW1'(COLUMNS)) begin
         put_x    = '0;
         put_y    = put_y + 1'b1;
         put_tpos = '0;
      end
      put_scroll = (put_y >= YW1'(ROWS));
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      lin_in       = lin_ff;
      base_in      = base_ff;
      tpos_in      = tpos_ff;
      cnt_in       = cnt_ff;
      sw_in        = sw_ff;
      sw_base_in   = sw_base_ff;
      sw_last_in   = sw_last_ff;
      ch_in        = ch_ff;
      rd_lin_in    = rd_lin_ff;
      rd_ok_in     = rd_ok_ff;
      cell_char_in = cell_char_ff;
      cell_attr_in = cell_attr_ff;
      unique case (state_ff)
         S_INIT: begin
            sw_in = sw_ff + 1'b1;
            if (sw_ff == sw_last_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               ch_in        = req.char_code;
               cell_char_in = '0;
               cell_attr_in = '0;
               rd_ok_in     = (int'(req.read_row) < ROWS) && (int'(req.read_col) < COLUMNS);
               rd_lin_in    = LW'(int'(req.read_row) * COLUMNS + int'(req.read_col));
               unique case (req.action)
                  ACT_WRITE: begin
                     if (req.char_code == CH_TAB) begin
                        ch_in  = CH_SPACE;
                        cnt_in = NW'(TAB_STOP) - NW'(tpos_ff);
                     end else begin
                        cnt_in = NW'(1);
                     end
                     state_in = S_PUT;
                  end
                  ACT_CLEAR: begin
                     x_in       = '0;
                     y_in       = '0;
                     lin_in     = '0;
                     tpos_in    = '0;
                     sw_in      = '0;
                     sw_base_in = '0;
                     sw_last_in = LW'(CELLS - 1);
                     state_in   = S_CLEAR;
                  end
                  ACT_READ: begin
                     state_in = S_RDADDR;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_PUT: begin
            cnt_in  = cnt_ff - 1'b1;
            x_in    = put_x[XW-1:0];
            y_in    = put_y[YW-1:0];
            lin_in  = put_lin[LW-1:0];
            tpos_in = put_tpos;
            if (put_scroll) begin
               // old top row becomes the blank bottom row
               y_in       = YW'(ROWS - 1);
               lin_in     = LW'((ROWS - 1) * COLUMNS);
               base_in    = base_next;
               sw_base_in = base_ff;
               sw_in      = '0;
               sw_last_in = LW'(COLUMNS - 1);
               state_in   = S_SCROLL;
            end else if (cnt_ff == NW'(1)) begin
               state_in = S_DONE;
            end
         end
         S_SCROLL: begin
            sw_in = sw_ff + 1'b1;
            if (sw_ff == sw_last_ff) begin
               state_in = (cnt_ff == '0) ? S_DONE : S_PUT;
            end
         end
         S_CLEAR: begin
            sw_in = sw_ff + 1'b1;
            if (sw_ff == sw_last_ff) begin
               state_in = S_DONE;
            end
         end
         S_RDADDR: begin
            state_in = S_RDDATA;
         end
         S_RDDATA: begin
            if (rd_ok_ff) begin
               cell_char_in = mem_rd_char;
               cell_attr_in = mem_rd_attr;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         x_ff       <= '0;
         y_ff       <= '0;
         lin_ff     <= '0;
         base_ff    <= '0;
         tpos_ff    <= '0;
         cnt_ff     <= '0;
         sw_ff      <= '0;
         sw_base_ff <= '0;
         sw_last_ff <= LW'(CELLS - 1);
      end else begin
         state_ff   <= state_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         lin_ff     <= lin_in;
         base_ff    <= base_in;
         tpos_ff    <= tpos_in;
         cnt_ff     <= cnt_in;
         sw_ff      <= sw_in;
         sw_base_ff <= sw_base_in;
         sw_last_ff <= sw_last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      rd_lin_ff    <= rd_lin_in;
      rd_ok_ff     <= rd_ok_in;
      cell_char_ff <= cell_char_in;
      cell_attr_ff <= cell_attr_in;
   end

   // memory port control
   always_comb begin
      mem_we.char_we = 1'b0;
      mem_we.attr_we = 1'b0;
      mem_wr_addr    = sweep_addr;
      mem_wr_char    = CH_SPACE;
      mem_wr_attr    = default_attr;
      unique case (state_ff)
         S_INIT: begin
            mem_we.char_we = 1'b1;
            mem_we.attr_we = 1'b1;
            mem_wr_attr    = ATTR_RESET;
         end
         S_SCROLL: begin
            mem_we.char_we = 1'b1;
            mem_we.attr_we = 1'b1;
         end
         S_CLEAR: begin
            mem_we.char_we = 1'b1;
         end
         S_PUT: begin
            mem_we.char_we = put_wr;
            mem_wr_addr    = phys_addr;
            mem_wr_char    = ch_ff;
         end
         default: begin
            mem_we.char_we = 1'b0;
         end
      endcase
   end

   assign mem_rd_en   = (state_ff == S_RDADDR) && rd_ok_ff;
   assign mem_rd_addr = phys_addr;

   assign idle                   = (state_ff == S_IDLE);
   assign done.valid             = (state_ff == S_DONE);
   assign done.rsp.cursor_col    = 7'(x_ff);
   assign done.rsp.cursor_row    = 5'(y_ff);
   assign done.rsp.cursor_offset = 11'(lin_ff);
   assign done.rsp.cell_char     = cell_char_ff;
   assign done.rsp.cell_attr     = cell_attr_ff;

`ifndef SYNTH
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (int'(x_ff) < COLUMNS) && (int'(y_ff) < ROWS))
      else $error("cursor outside the screen");

   a_offset_track: assert property (@(posedge clock) disable iff (reset)
      int'(lin_ff) == int'(y_ff) * COLUMNS + int'(x_ff))
      else $error("cursor offset lost track of row and column");

   a_base_range: assert property (@(posedge clock) disable iff (reset)
      int'(base_ff) < CELLS)
      else $error("top-row base outside the screen");

   a_put_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |-> (cnt_ff != '0))
      else $error("character step with nothing left to put");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && !out_free |=> (state_ff == S_DONE))
      else $error("result dropped while output register busy");
`endif

endmodule

// File: rtl/text_console_cursor_scroll_unit.sv
// ---------------------------------------------------------------------------
// Text console cursor/scroll unit
// Screen of character and attribute cells with a cursor, scrolling and reads.
// ---------------------------------------------------------------------------
// One item at a time is worked on, and each gives one result item through
// an output register. A tab is written as spaces up to the next tab stop;
// each scroll blanks the new bottom row through the single memory write
// port; clear blanks the characters of every cell, one cell per cycle; a
// read goes through the registered memory read port; an unused action
// code gives its result with no memory access. While the output register
// holds a result that has not been taken, the unit waits in its last step.
// After reset the unit sweeps all ROWS*COLUMNS cells of the screen memory
// to spaces (2000 by default) before it takes the first item; the
// attribute register may be written during that sweep. Write default_attr
// only while the unit is idle.
module text_console_cursor_scroll_unit #(
   parameter int COLUMNS  = tccs_pkg::COLUMNS_DEF,
   parameter int ROWS     = tccs_pkg::ROWS_DEF,
   parameter int TAB_STOP = tccs_pkg::TAB_STOP_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tccs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tccs_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);
   import tccs_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   logic          idle;
   logic          start;
   logic          out_free;
   done_type      done;
   logic [7:0]    default_attr_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   mem_we_type    mem_we;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_char;
   logic [7:0]    mem_wr_attr;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_char;
   logic [7:0]    mem_rd_attr;

   assign req_stall = !idle;
   assign start     = req_valid && idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // attribute register for blanked rows
   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= ATTR_RESET;
      end else if (csr_wr_en) begin
         default_attr_ff <= csr_wr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && done.valid) begin
         rsp_data_ff <= done.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tccs_seq #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP),
      .AW       (AW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req          (req_data),
      .idle         (idle),
      .default_attr (default_attr_ff),
      .out_free     (out_free),
      .done         (done),
      .mem_we       (mem_we),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_char  (mem_wr_char),
      .mem_wr_attr  (mem_wr_attr),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_char  (mem_rd_char),
      .mem_rd_attr  (mem_rd_attr)
   );

   tccs_screen_mem #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_char (mem_wr_char),
      .wr_attr (mem_wr_attr),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_char (mem_rd_char),
      .rd_attr (mem_rd_attr)
   );

endmodule
